// ----- src/agpu_pkg.sv -----
package agpu_pkg;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_SCALED  = 2'd1;
  localparam logic [1:0] MODE_ADAGRAD = 2'd2;
  localparam logic [1:0] MODE_ADAREV  = 2'd3;

  localparam logic OP_APPLY = 1'b0;
  localparam logic OP_SNAP  = 1'b1;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_RATE = 1'b1;

  localparam logic [30:0] RATE_RESET = 31'd655;

  // root / divide unit widths
  localparam int RAD_W    = 48;
  localparam int NUM_W    = 63;
  localparam int DEN_W    = 24;
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int CNT_W    = 6;

  localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
  localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    if (x > SAT_MAX) return 32'sh7fff_ffff;
    if (x < SAT_MIN) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic clipped32(input logic signed [64:0] x);
    return (x > SAT_MAX) || (x < SAT_MIN);
  endfunction

endpackage

// ----- src/agpu_divsqrt.sv -----
module agpu_divsqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  agpu_pkg::ds_req_t              req,
  input  logic [agpu_pkg::RAD_W-1:0]     radicand,
  input  logic [agpu_pkg::NUM_W-1:0]     num,
  input  logic [agpu_pkg::DEN_W-1:0]     den,
  output logic                           done,
  output logic [agpu_pkg::NUM_W-1:0]     result
);

  logic                           busy;
  logic                           is_sqrt_r;
  logic [agpu_pkg::CNT_W-1:0]     cnt;
  logic [agpu_pkg::CNT_W-1:0]     last;
  logic [agpu_pkg::RAD_W-1:0]     v;
  logic [agpu_pkg::RAD_W-1:0]     res;
  logic [agpu_pkg::RAD_W-1:0]     bitm;
  logic [agpu_pkg::RAD_W-1:0]     sq_sum;
  logic [agpu_pkg::DEN_W-1:0]     rem;
  logic [agpu_pkg::DEN_W-1:0]     den_r;
  logic [agpu_pkg::NUM_W-1:0]     quo;
  logic [agpu_pkg::DEN_W:0]       trial;

  assign last   = is_sqrt_r ? agpu_pkg::CNT_W'(agpu_pkg::SQ_STEPS - 1)
                            : agpu_pkg::CNT_W'(agpu_pkg::NUM_W - 1);
  assign sq_sum = res + bitm;
  assign trial  = {rem, quo[agpu_pkg::NUM_W-1]};
  assign result = is_sqrt_r ? agpu_pkg::NUM_W'(res) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy      <= 1'b1;
        is_sqrt_r <= req.is_sqrt;
        cnt       <= '0;
        v         <= radicand;
        res       <= '0;
        bitm      <= agpu_pkg::RAD_W'(1) << (agpu_pkg::RAD_W - 2);
        rem       <= '0;
        quo       <= num;
        den_r     <= den;
      end else if (busy) begin
        if (is_sqrt_r) begin
          if (v >= sq_sum) begin
            v   <= v - sq_sum;
            res <= (res >> 1) + bitm;
          end else begin
            res <= res >> 1;
          end
          bitm <= bitm >> 2;
        end else begin
          if (trial >= {1'b0, den_r}) begin
            rem <= agpu_pkg::DEN_W'(trial - {1'b0, den_r});
            quo <= {quo[agpu_pkg::NUM_W-2:0], 1'b1};
          end else begin
            rem <= trial[agpu_pkg::DEN_W-1:0];
            quo <= {quo[agpu_pkg::NUM_W-2:0], 1'b0};
          end
        end
        cnt <= cnt + 1'b1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/adaptive_gradient_param_update.sv -----
// Parameter store of TABLE_ROWS x ROW_WIDTH signed Q16.16 weights with add, scaled,
// AdaGrad and AdaRevision update rules. After reset a clearing pass over all
// TABLE_ROWS*ROW_WIDTH entries zeroes all stores before the first item is taken;
// configuration writes are taken at any time. One item at a time: each item runs
// to completion before the next is taken, paced in the AdaGrad and AdaRevision
// rules by the shared root/divide unit, which retires one bit per cycle (24 result
// bits a root, 63 a divide). A snapshot item walks every entry, reading it in
// S_SNAP_RD and writing its sum to the snapshot store in S_SNAP_WR.
module adaptive_gradient_param_update #(
  parameter int TABLE_ROWS = 256,
  parameter int ROW_WIDTH  = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic [7:0]         row_index,
  input  logic [2:0]         column,
  input  logic signed [31:0] gradient,
  input  logic               first_pass,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] weight_value,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int ENTRIES = TABLE_ROWS * ROW_WIDTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [23:0] {
    S_CLEAR     = 24'h000001,
    S_IDLE      = 24'h000002,
    S_READ      = 24'h000004,
    S_LOAD      = 24'h000008,
    S_MUL_LG    = 24'h000010,
    S_SCALE     = 24'h000020,
    S_SQG       = 24'h000040,
    S_ACC2      = 24'h000080,
    S_ZA        = 24'h000100,
    S_MUL_GB    = 24'h000200,
    S_ZB        = 24'h000400,
    S_ROOT_GO   = 24'h000800,
    S_ROOT_WAIT = 24'h001000,
    S_DIV_GO    = 24'h002000,
    S_DIV_WAIT  = 24'h004000,
    S_MUL_E1G   = 24'h008000,
    S_MUL_DB    = 24'h010000,
    S_SUM       = 24'h020000,
    S_FIN       = 24'h040000,
    S_WRITE     = 24'h080000,
    S_SNAP_RD   = 24'h100000,
    S_SNAP_WR   = 24'h200000,
    S_DONE      = 24'h400000,
    S_SPARE     = 24'h800000
  } state_t;

  state_t state;

  logic [1:0]  mode_r;
  logic [30:0] lr_r;

  logic [AW-1:0]      addr_r;
  logic [AW-1:0]      cnt;
  logic [AW-1:0]      mem_addr;
  logic signed [31:0] g_r;
  logic               first_r;
  logic               pass_r;
  logic [1:0]         mode_eff;

  logic signed [31:0] w_mem    [ENTRIES];
  logic signed [31:0] acc_mem  [ENTRIES];
  logic signed [31:0] snap_mem [ENTRIES];
  logic signed [31:0] z_mem    [ENTRIES];
  logic signed [31:0] zmax_mem [ENTRIES];
  logic signed [31:0] w_rd, acc_rd, snap_rd, z_rd, zmax_rd;
  logic               mem_we, snap_we;
  logic               clearing;

  logic signed [31:0] w_r, acc_r, z_r, zmax_r, b_r, e0_r, e1_r;
  logic               sat_r;
  logic signed [63:0] prod_r, p1_r, t_r, addend_r;
  logic [23:0]        root_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [64:0] b_full, zsum, wsum;
  logic signed [31:0] z_new;

  logic signed [31:0]           root_src;
  logic signed [32:0]           root_sum;
  logic [agpu_pkg::RAD_W-1:0]   radicand;
  logic [agpu_pkg::NUM_W-1:0]   div_num;
  logic signed [63:0]           p_mag;
  logic                         q_neg;
  logic signed [63:0]           q_signed;
  agpu_pkg::ds_req_t            ds_req;
  logic                         ds_done;
  logic [agpu_pkg::NUM_W-1:0]   ds_result;

  logic [31:0] k_full;
  logic        in_range;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mode_eff  = first_r ? agpu_pkg::MODE_ADD : mode_r;

  assign k_full   = 32'(row_index) * 32'(ROW_WIDTH) + 32'(column);
  assign in_range = (32'(row_index) < 32'(TABLE_ROWS)) && (32'(column) < 32'(ROW_WIDTH));

  // stores
  assign clearing = (state == S_CLEAR);
  assign mem_addr = (clearing || state == S_SNAP_RD || state == S_SNAP_WR) ? cnt : addr_r;
  assign mem_we   = clearing || (state == S_WRITE);
  assign snap_we  = clearing || (state == S_SNAP_WR);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      w_mem[mem_addr]    <= clearing ? 32'sd0 : w_r;
      acc_mem[mem_addr]  <= clearing ? 32'sd0 : acc_r;
      z_mem[mem_addr]    <= clearing ? 32'sd0 : z_r;
      zmax_mem[mem_addr] <= clearing ? 32'sd0 : zmax_r;
    end
    if (snap_we) begin
      snap_mem[mem_addr] <= clearing ? 32'sd0 : acc_rd;
    end
    w_rd    <= w_mem[mem_addr];
    acc_rd  <= acc_mem[mem_addr];
    snap_rd <= snap_mem[mem_addr];
    z_rd    <= z_mem[mem_addr];
    zmax_rd <= zmax_mem[mem_addr];
  end

  // shared multiplier
  always_comb begin
    case (state)
      S_MUL_LG:  begin mul_a = $signed({1'b0, lr_r}); mul_b = g_r; end
      S_MUL_GB:  begin mul_a = g_r;                   mul_b = b_r; end
      S_MUL_E1G: begin mul_a = e1_r;                  mul_b = g_r; end
      S_MUL_DB:  begin mul_a = e1_r - e0_r;           mul_b = b_r; end
      default:   begin mul_a = g_r;                   mul_b = g_r; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign b_full = 65'(acc_rd) - 65'(snap_rd);
  assign zsum   = 65'(t_r) + 65'(prod_r >>> 15);
  assign z_new  = agpu_pkg::sat32(zsum);
  assign wsum   = 65'(w_r) + 65'(addend_r);

  // root argument: max(v + one, one) in Q16.16, scaled by 2^16
  assign root_src = (mode_r == agpu_pkg::MODE_ADAGRAD) ? acc_r : zmax_r;
  assign root_sum = 33'(root_src) + 33'sd65536;
  assign radicand = {(root_src[31] ? 32'h0001_0000 : root_sum[31:0]), 16'h0000};

  assign p_mag    = prod_r[63] ? -prod_r : prod_r;
  assign q_neg    = (mode_r == agpu_pkg::MODE_ADAGRAD) && prod_r[63];
  assign div_num  = (mode_r == agpu_pkg::MODE_ADAGRAD) ? p_mag[agpu_pkg::NUM_W-1:0]
                                                       : {16'h0000, lr_r, 16'h0000};
  assign q_signed = q_neg ? -$signed({1'b0, ds_result}) : $signed({1'b0, ds_result});

  assign ds_req.start   = (state == S_ROOT_GO) || (state == S_DIV_GO);
  assign ds_req.is_sqrt = (state == S_ROOT_GO);

  agpu_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .req      (ds_req),
    .radicand (radicand),
    .num      (div_num),
    .den      (root_r),
    .done     (ds_done),
    .result   (ds_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
      mode_r    <= agpu_pkg::MODE_ADD;
      lr_r      <= agpu_pkg::RATE_RESET;
      pass_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          agpu_pkg::CFG_MODE: mode_r <= cfg_data[1:0];
          agpu_pkg::CFG_RATE: lr_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          if (cnt == AW'(ENTRIES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            addr_r  <= k_full[AW-1:0];
            g_r     <= gradient;
            first_r <= first_pass;
            w_r     <= 32'sd0;
            sat_r   <= 1'b0;
            cnt     <= '0;
            if (op == agpu_pkg::OP_SNAP) state <= S_SNAP_RD;
            else if (!in_range)          state <= S_DONE;
            else                         state <= S_READ;
          end
        end
        S_READ: state <= S_LOAD;
        S_LOAD: begin
          w_r      <= w_rd;
          acc_r    <= acc_rd;
          z_r      <= z_rd;
          zmax_r   <= zmax_rd;
          b_r      <= agpu_pkg::sat32(b_full);
          pass_r   <= 1'b0;
          addend_r <= 64'(g_r);
          case (mode_eff)
            agpu_pkg::MODE_ADD:     state <= S_FIN;
            agpu_pkg::MODE_SCALED:  state <= S_MUL_LG;
            agpu_pkg::MODE_ADAGRAD: state <= S_SQG;
            default: begin
              sat_r <= agpu_pkg::clipped32(b_full);
              state <= S_ROOT_GO;
            end
          endcase
        end
        S_MUL_LG: begin
          prod_r <= prod;
          state  <= (mode_eff == agpu_pkg::MODE_SCALED) ? S_SCALE : S_DIV_GO;
        end
        S_SCALE: begin
          addend_r <= prod_r >>> 16;
          state    <= S_FIN;
        end
        S_SQG: begin
          prod_r <= prod;
          state  <= (mode_eff == agpu_pkg::MODE_ADAGRAD) ? S_ACC2 : S_ZA;
        end
        S_ACC2: begin
          acc_r <= agpu_pkg::sat32(65'(acc_r) + 65'(prod_r >>> 16));
          sat_r <= sat_r | agpu_pkg::clipped32(65'(acc_r) + 65'(prod_r >>> 16));
          state <= S_ROOT_GO;
        end
        S_ZA: begin
          t_r   <= 64'(z_r) + (prod_r >>> 16);
          state <= S_MUL_GB;
        end
        S_MUL_GB: begin
          prod_r <= prod;
          state  <= S_ZB;
        end
        S_ZB: begin
          z_r    <= z_new;
          sat_r  <= sat_r | agpu_pkg::clipped32(zsum);
          if (z_new > zmax_r) zmax_r <= z_new;
          pass_r <= 1'b1;
          state  <= S_ROOT_GO;
        end
        S_ROOT_GO: state <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (ds_done) begin
            root_r <= ds_result[23:0];
            state  <= (mode_eff == agpu_pkg::MODE_ADAGRAD) ? S_MUL_LG : S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (ds_done) begin
            if (mode_eff == agpu_pkg::MODE_ADAGRAD) begin
              addend_r <= q_signed;
              state    <= S_FIN;
            end else if (!pass_r) begin
              e0_r  <= q_signed[31:0];
              state <= S_SQG;
            end else begin
              e1_r  <= q_signed[31:0];
              state <= S_MUL_E1G;
            end
          end
        end
        S_MUL_E1G: begin
          prod_r <= prod;
          state  <= S_MUL_DB;
        end
        S_MUL_DB: begin
          p1_r   <= prod_r;
          prod_r <= prod;
          state  <= S_SUM;
        end
        S_SUM: begin
          addend_r <= 64'((65'(p1_r) + 65'(prod_r)) >>> 16);
          acc_r    <= agpu_pkg::sat32(65'(acc_r) + 65'(g_r));
          sat_r    <= sat_r | agpu_pkg::clipped32(65'(acc_r) + 65'(g_r));
          state    <= S_FIN;
        end
        S_FIN: begin
          w_r   <= agpu_pkg::sat32(wsum);
          sat_r <= sat_r | agpu_pkg::clipped32(wsum);
          state <= S_WRITE;
        end
        S_WRITE: state <= S_DONE;
        S_SNAP_RD: state <= S_SNAP_WR;
        S_SNAP_WR: begin
          if (cnt == AW'(ENTRIES - 1)) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_SNAP_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            weight_value <= w_r;
            saturated    <= sat_r;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_ds_done: assert property (@(posedge clk) disable iff (rst)
    ds_done |-> (state == S_ROOT_WAIT || state == S_DIV_WAIT))
    else $error("root/divide result with nobody waiting");

  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside done state");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready && !out_valid)
    else $error("activity during clearing pass");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int ENTRIES = 256 * 8;

  typedef struct {
    logic              op;
    logic [7:0]        row_index;
    logic [2:0]        column;
    logic signed [31:0] gradient;
    logic              first_pass;
  } grad_item_t;

  typedef struct {
    logic signed [31:0] weight_value;
    logic              saturated;
  } weight_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [7:0] row_index = '0;
  logic [2:0] column = '0;
  logic signed [31:0] gradient = '0;
  logic first_pass = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] weight_value;
  logic saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = agpu_pkg::CFG_MODE;
  logic [31:0] cfg_data = '0;

  grad_item_t     pending_items[$];
  weight_result_t expected_weights[$];
  int errors = 0;
  int send_gap = 0;
  bit send_idling = 1'b1;
  bit recv_idling = 1'b1;

  logic [1:0]  cur_mode;
  logic [30:0] cur_rate;
  int weights[ENTRIES];
  int grad_sums[ENTRIES];
  int grad_snap[ENTRIES];
  int rev_z[ENTRIES];
  int rev_zmax[ENTRIES];
  bit clip_seen;

  adaptive_gradient_param_update DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .row_index(row_index), .column(column),
    .gradient(gradient), .first_pass(first_pass),
    .out_valid(out_valid), .out_ready(out_ready),
    .weight_value(weight_value), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int clamp_q16(longint x);
    if (x > 64'sd2147483647) begin
      clip_seen = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (x < -64'sd2147483648) begin
      clip_seen = 1'b1;
      return 32'sh8000_0000;
    end
    return int'(x);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint root_plus_one(int v);
    longint a;
    a = longint'(v) + 65536;
    if (a < 65536) a = 65536;
    return longint'(int_sqrt(longint'(a) << 16));
  endfunction

  function automatic weight_result_t predict_update(grad_item_t it);
    weight_result_t r;
    int k;
    int w;
    int acc;
    int z;
    longint g;
    longint lr;
    longint b;
    longint e0;
    longint e1;
    r.weight_value = '0;
    r.saturated = 1'b0;
    clip_seen = 1'b0;
    if (it.op == agpu_pkg::OP_SNAP) begin
      for (int i = 0; i < ENTRIES; i++) grad_snap[i] = grad_sums[i];
      return r;
    end
    k = it.row_index * 8 + it.column;
    w = weights[k];
    g = longint'(it.gradient);
    lr = longint'({1'b0, cur_rate});
    if (it.first_pass || cur_mode == agpu_pkg::MODE_ADD) begin
      w = clamp_q16(longint'(w) + g);
    end else if (cur_mode == agpu_pkg::MODE_SCALED) begin
      w = clamp_q16(longint'(w) + ((lr * g) >>> 16));
    end else if (cur_mode == agpu_pkg::MODE_ADAGRAD) begin
      acc = clamp_q16(longint'(grad_sums[k]) + ((g * g) >>> 16));
      grad_sums[k] = acc;
      w = clamp_q16(longint'(w) + (lr * g) / root_plus_one(acc));
    end else begin
      b = clamp_q16(longint'(grad_sums[k]) - longint'(grad_snap[k]));
      e0 = (lr * 65536) / root_plus_one(rev_zmax[k]);
      z = clamp_q16(longint'(rev_z[k]) + ((g * g) >>> 16) + ((g * b) >>> 15));
      rev_z[k] = z;
      if (z > rev_zmax[k]) rev_zmax[k] = z;
      e1 = (lr * 65536) / root_plus_one(rev_zmax[k]);
      w = clamp_q16(longint'(w) + ((e1 * g + (e1 - e0) * b) >>> 16));
      grad_sums[k] = clamp_q16(longint'(grad_sums[k]) + g);
    end
    weights[k] = w;
    r.weight_value = w;
    r.saturated = clip_seen;
    return r;
  endfunction

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    grad_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        it.op = op;
        it.row_index = row_index;
        it.column = column;
        it.gradient = gradient;
        it.first_pass = first_pass;
        expected_weights.insert(expected_weights.size(), predict_update(it));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          it = pending_items.pop_front();
          op <= it.op;
          row_index <= it.row_index;
          column <= it.column;
          gradient <= it.gradient;
          first_pass <= it.first_pass;
          in_valid <= 1'b1;
          send_gap <= pick_gap(send_idling);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    weight_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_weights.size() == 0) begin
          $error("result with nothing expected: weight_value %0d", weight_value);
          errors++;
        end else begin
          e = expected_weights.pop_front();
          if (weight_value !== e.weight_value) begin
            $error("weight_value expected %0d actual %0d", e.weight_value, weight_value);
            errors++;
          end
          if (saturated !== e.saturated) begin
            $error("saturated expected %0d actual %0d", e.saturated, saturated);
            errors++;
          end
        end
      end
      out_ready <= (pick_gap(recv_idling) == 0);
    end
  end

  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == agpu_pkg::CFG_MODE) cur_mode = data[1:0];
    else cur_rate = data[30:0];
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || expected_weights.size() != 0 || in_valid);
    repeat (10) @(posedge clk);
  endtask

  task automatic push_item(logic o, logic [7:0] r, logic [2:0] c, logic [31:0] g, logic f);
    grad_item_t it;
    it.op = o;
    it.row_index = r;
    it.column = c;
    it.gradient = g;
    it.first_pass = f;
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic logic [31:0] rand_gradient();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h2_0000)
                                     : -$urandom_range(0, 32'h2_0000);
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h40_0000)
                                           : -$urandom_range(0, 32'h40_0000);
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [7:0] r;
    for (int i = 0; i < count; i++) begin
      r = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom());
      push_item(($urandom_range(0, 99) < 2) ? agpu_pkg::OP_SNAP : agpu_pkg::OP_APPLY,
                r, 3'($urandom()), rand_gradient(), $urandom_range(0, 19) == 0);
    end
    wait_drained();
  endtask

  initial begin
    logic [1:0]  modes[8];
    logic [31:0] rates[8];
    cur_mode = agpu_pkg::MODE_ADD;
    cur_rate = agpu_pkg::RATE_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      weights[i] = 0;
      grad_sums[i] = 0;
      grad_snap[i] = 0;
      rev_z[i] = 0;
      rev_zmax[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // extremes and saturation in the reset configuration
    push_item(agpu_pkg::OP_APPLY, 8'd0, 3'd0, 32'h7fff_ffff, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd0, 3'd0, 32'h0000_0001, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd255, 3'd7, 32'h8000_0000, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd255, 3'd7, 32'hffff_ffff, 1'b1);
    push_item(agpu_pkg::OP_SNAP, 8'hff, 3'd7, 32'hffff_ffff, 1'b1);
    push_item(agpu_pkg::OP_APPLY, 8'd1, 3'd2, 32'h0001_0000, 1'b0);
    wait_drained();

    write_reg(agpu_pkg::CFG_MODE, {30'h3fff_ffff, agpu_pkg::MODE_ADAREV});
    write_reg(agpu_pkg::CFG_RATE, 32'h8001_0000);
    push_item(agpu_pkg::OP_APPLY, 8'd2, 3'd1, 32'h0002_0000, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd2, 3'd1, 32'hfffe_0000, 1'b0);
    push_item(agpu_pkg::OP_SNAP, 8'd0, 3'd0, 32'h0, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd2, 3'd1, 32'h8000_0000, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd2, 3'd1, 32'h7fff_ffff, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd2, 3'd1, 32'h0005_0000, 1'b1);
    push_item(agpu_pkg::OP_APPLY, 8'd3, 3'd4, 32'h8000_0000, 1'b0);
    wait_drained();

    // negative sums left by the previous mode feed the root
    write_reg(agpu_pkg::CFG_MODE, {30'h0, agpu_pkg::MODE_ADAGRAD});
    push_item(agpu_pkg::OP_APPLY, 8'd3, 3'd4, 32'h0000_8000, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd2, 3'd1, 32'hffff_0000, 1'b0);
    wait_drained();
    write_reg(agpu_pkg::CFG_MODE, {30'h0, agpu_pkg::MODE_SCALED});
    push_item(agpu_pkg::OP_APPLY, 8'd5, 3'd5, 32'h7fff_ffff, 1'b0);
    push_item(agpu_pkg::OP_APPLY, 8'd5, 3'd5, 32'h8000_0000, 1'b0);
    wait_drained();

    modes = '{agpu_pkg::MODE_SCALED, agpu_pkg::MODE_SCALED, agpu_pkg::MODE_ADAGRAD,
              agpu_pkg::MODE_ADAREV, agpu_pkg::MODE_ADAREV, agpu_pkg::MODE_ADAGRAD,
              agpu_pkg::MODE_ADD, agpu_pkg::MODE_ADAREV};
    rates = '{32'h0, 32'hffff_ffff, 32'h0001_0000, $urandom(),
              32'h7fff_ffff, $urandom_range(0, 32'h4_0000), $urandom(), 32'd655};
    for (int p = 0; p < 8; p++) begin
      send_idling = (p != 2);
      recv_idling = (p != 2) && (p != 5);
      write_reg(agpu_pkg::CFG_MODE, {30'($urandom()), modes[p]});
      write_reg(agpu_pkg::CFG_RATE, rates[p]);
      random_phase(210);
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd40_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
